// File: sv/deq_pkg.sv
// Package for the double-ended queue: operation and status codes, field widths,
// sequencer state type and the step struct between pointer logic and top level.
// No dependencies.
`default_nettype none

package deq_pkg;

    // Field widths of the streaming payload
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - COUNT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [0:0] {
        DEQ_IDLE,
        DEQ_READ
    } deq_state_t;

    // Decoded step from the pointer logic
    typedef struct packed {
        logic                we;
        logic                re;
        logic [STATUS_W-1:0] status;
    } deq_step_t;

endpackage

`default_nettype wire

// File: sv/deq_ram.sv
// Entry store of the double-ended queue: single-address synchronous RAM,
// one write or one registered read per cycle. No package dependencies.
`default_nettype none

module deq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         addr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/deq_ptr.sv
// Front/back pointers and entry count of the double-ended queue; decodes one
// operation into a store access and a status. Depends on deq_pkg.
`default_nettype none

module deq_ptr #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_valid,
    input  wire logic [deq_pkg::OP_W-1:0]     op,
    output deq_pkg::deq_step_t                step,
    output logic      [AW-1:0]                addr,
    output logic      [CW-1:0]                count_after
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg,  back_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
    logic          is_full, is_empty;

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + AW'(1);
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - AW'(1);
    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        step.we     = 1'b0;
        step.re     = 1'b0;
        step.status = deq_pkg::ST_OK;
        addr        = front_reg;
        case (op)
            deq_pkg::OP_PUSH_FRONT: begin
                addr = front_dec;
                if (is_full) begin
                    step.status = deq_pkg::ST_FULL;
                end else begin
                    step.we    = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                addr = back_reg;
                if (is_full) begin
                    step.status = deq_pkg::ST_FULL;
                end else begin
                    step.we    = 1'b1;
                    back_next  = back_inc;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                addr = front_reg;
                if (is_empty) begin
                    step.status = deq_pkg::ST_EMPTY;
                end else begin
                    step.re    = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                addr = back_dec;
                if (is_empty) begin
                    step.status = deq_pkg::ST_EMPTY;
                end else begin
                    step.re    = 1'b1;
                    back_next  = back_dec;
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::OP_CLEAR: begin
                front_next = '0;
                back_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
        // no store access unless the operation is taken
        if (!step_valid) begin
            step.we = 1'b0;
            step.re = 1'b0;
        end
    end

    assign count_after = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (step_valid) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/double_ended_queue.sv
// Top level of the double-ended queue: transfer handshakes, sequencer and
// result register. Depends on deq_pkg, deq_ptr and deq_ram.
//
// Usage
//   Input channel (s_): s_tuser carries the operation (push front, push back,
//   pop front, pop back, clear); s_tdata carries the word to push. Result
//   channel (m_): one transfer per input transfer, in order; m_tdata holds
//   the popped word and the entry count after the step, m_tuser the status
//   (ok, pop on empty queue, push on full queue).
//   Result path: pushes, clear, unused codes and rejected pops give their result
//   in the cycle after the input transfer; a successful pop first reads the
//   single-port entry store, whose read data is registered, and loads its
//   result in the read state.
//   Throughput: one item per cycle while no result is stalled, for everything
//   but successful pops, which hold the input while the store read completes.
//   Reset: pointers and count return to zero and the result register empties;
//   the store contents are not cleared, which needs no sweep since only
//   entries already pushed are ever read.
//   Stall: while a result waits with m_tready low, hold it stable and drop
//   s_tready; a new item is taken in the same cycle that the waiting result
//   is transferred.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [31:0] push_value
    input  wire logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: [2:0] op
    input  wire logic [deq_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [31:0] pop_value, [36:32] count, [39:37] zero
    output logic      [deq_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: [1:0] status
    output logic      [deq_pkg::STATUS_W-1:0]    m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;

    deq_pkg::deq_state_t state_reg, state_next;
    logic                           m_valid_reg, m_valid_next;
    logic [deq_pkg::VALUE_W-1:0]    pop_reg;
    logic [deq_pkg::STATUS_W-1:0]   status_reg;
    logic [deq_pkg::COUNT_W-1:0]    count_reg;

    logic                           accept;
    deq_pkg::deq_step_t             step;
    logic [AW-1:0]                  mem_addr;
    logic [CW-1:0]                  count_after;
    logic [DATA_WIDTH-1:0]          wr_word;
    logic [DATA_WIDTH-1:0]          rd_word;
    logic signed [EXT_W-1:0]        rd_ext;

    // Take a new item only with the sequencer idle and the result slot free
    // or emptying this cycle.
    assign s_tready = (state_reg == deq_pkg::DEQ_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Keep the low bits of the pushed word.
    assign wr_word = DATA_WIDTH'(EXT_W'(s_tdata));

    deq_ptr #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_deq_ptr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_valid  (accept),
        .op          (s_tuser),
        .step        (step),
        .addr        (mem_addr),
        .count_after (count_after)
    );

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_deq_ram (
        .aclk  (aclk),
        .we    (step.we),
        .re    (step.re),
        .addr  (mem_addr),
        .wdata (wr_word),
        .rdata (rd_word)
    );

    // Sign-extend the stored word, then keep the low 32 bits.
    assign rd_ext = EXT_W'($signed(rd_word));

    // Sequencer: a successful pop passes through the read state for the store read.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            deq_pkg::DEQ_IDLE: begin
                if (accept) begin
                    if (step.re) begin
                        state_next = deq_pkg::DEQ_READ;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            deq_pkg::DEQ_READ: begin
                state_next   = deq_pkg::DEQ_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = deq_pkg::DEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deq_pkg::DEQ_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: status and count at the transfer, popped word once read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= step.status;
            count_reg  <= deq_pkg::COUNT_W'(count_after);
            pop_reg    <= '0;
        end else if (state_reg == deq_pkg::DEQ_READ) begin
            pop_reg <= rd_ext[deq_pkg::VALUE_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{deq_pkg::M_PAD_W{1'b0}}, count_reg, pop_reg};

endmodule

`default_nettype wire

// File: sv/deq_checker.sv
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on deq_pkg and double_ended_queue.
`default_nettype none

module deq_port_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [deq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [deq_pkg::STATUS_W-1:0]  m_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    localparam logic [deq_pkg::COUNT_W-1:0] FULL_CNT = deq_pkg::COUNT_W'(DEPTH);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // No result straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A waiting result blocks new input.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // A pop on an empty queue leaves it empty and returns zero.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == deq_pkg::ST_EMPTY) |-> (m_tdata == '0))
        else $error("empty pop with non-zero word or count");

    // A rejected push reports a full queue and no word.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == deq_pkg::ST_FULL) |->
        (m_tdata[deq_pkg::VALUE_W-1:0] == '0 &&
         m_tdata[deq_pkg::VALUE_W+deq_pkg::COUNT_W-1:deq_pkg::VALUE_W] == FULL_CNT))
        else $error("full push with wrong word or count");

endmodule

bind double_ended_queue deq_port_checker #(.DEPTH(DEPTH)) u_deq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
